/* hdl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the line clipper: item structs, csr
// register indexes and the side data carried past the divider.
// ----------------------------------------------------------------------------
package lbc_pkg;

   // coordinate width of every endpoint and window register
   localparam int COORD_WIDTH = 16;
   // width of a difference of two coordinates
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int NUM_EDGES   = 4;
   localparam int CSR_AW      = 2;

   // csr register indexes
   localparam logic [CSR_AW-1:0] CSR_CLIP_LEFT   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_CLIP_RIGHT  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_CLIP_TOP    = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_CLIP_BOTTOM = 2'd3;

   // input item
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_start;
      logic signed [COORD_WIDTH-1:0] y_start;
      logic signed [COORD_WIDTH-1:0] x_end;
      logic signed [COORD_WIDTH-1:0] y_end;
   } req_type;

   // result item
   typedef struct packed {
      logic                          visible;
      logic signed [COORD_WIDTH-1:0] x_clip_start;
      logic signed [COORD_WIDTH-1:0] y_clip_start;
      logic signed [COORD_WIDTH-1:0] x_clip_end;
      logic signed [COORD_WIDTH-1:0] y_clip_end;
   } rsp_type;

   // per-edge classification plus segment geometry, carried beside the quotient
   typedef struct packed {
      logic [NUM_EDGES-1:0]         rej;
      logic [NUM_EDGES-1:0]         used;
      logic [NUM_EDGES-1:0]         entry;
      logic [NUM_EDGES-1:0]         one;
      logic signed [DIFF_WIDTH-1:0] xs;
      logic signed [DIFF_WIDTH-1:0] ys;
      logic signed [DIFF_WIDTH-1:0] dx;
      logic signed [DIFF_WIDTH-1:0] dy;
   } side_type;

endpackage

/* hdl/lbc_div.sv */
// ----------------------------------------------------------------------------
// lbc_div
// Pipelined restoring divider, four lanes: quotient floor(n * 2^F / d) for
// n < d, one quotient bit per stage, side data travels alongside.
// ----------------------------------------------------------------------------
module lbc_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                                      clock,
   input  logic                                                      reset,
   input  logic                                                      in_valid,
   input  logic [lbc_pkg::NUM_EDGES-1:0][lbc_pkg::DIFF_WIDTH-1:0]    in_num,
   input  logic [lbc_pkg::NUM_EDGES-1:0][lbc_pkg::DIFF_WIDTH-1:0]    in_den,
   input  lbc_pkg::side_type                                         in_side,
   output logic                                                      out_valid,
   output logic [lbc_pkg::NUM_EDGES-1:0][FRAC_BITS-1:0]              out_quo,
   output lbc_pkg::side_type                                         out_side
);

   localparam int NE = lbc_pkg::NUM_EDGES;
   localparam int DW = lbc_pkg::DIFF_WIDTH;
   localparam int RW = DW + 1;

   // stage k holds the partial remainder after k quotient bits
   logic                          valid_ff [FRAC_BITS+1];
   logic [NE-1:0][RW-1:0]         rem_ff   [FRAC_BITS];
   logic [NE-1:0][DW-1:0]         den_ff   [FRAC_BITS];
   logic [NE-1:0][FRAC_BITS-1:0]  quo_ff   [FRAC_BITS+1];
   lbc_pkg::side_type             side_ff  [FRAC_BITS+1];

   // stage 0 is the input itself
   always_comb begin
      valid_ff[0] = in_valid;
      side_ff[0]  = in_side;
      for (int e = 0; e < NE; e++) begin
         rem_ff[0][e] = {1'b0, in_num[e]};
         den_ff[0][e] = in_den[e];
         quo_ff[0][e] = '0;
      end
   end

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic [NE-1:0][RW-1:0]        rem_in;
      logic [NE-1:0][FRAC_BITS-1:0] quo_in;

      // shift, compare and subtract
      always_comb begin
         for (int e = 0; e < NE; e++) begin
            rem_in[e] = {rem_ff[k][e][RW-2:0], 1'b0};
            quo_in[e] = {quo_ff[k][e][FRAC_BITS-2:0], 1'b0};
            if (rem_in[e] >= {1'b0, den_ff[k][e]}) begin
               rem_in[e]    = rem_in[e] - {1'b0, den_ff[k][e]};
               quo_in[e][0] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         quo_ff[k+1]  <= quo_in;
         side_ff[k+1] <= side_ff[k];
      end

      // the last stage needs no remainder or divisor after it
      if (k < FRAC_BITS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= rem_in;
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[FRAC_BITS];
   assign out_quo   = quo_ff[FRAC_BITS];
   assign out_side  = side_ff[FRAC_BITS];

endmodule

/* hdl/liang_barsky_line_clip_top.sv */
// ----------------------------------------------------------------------------
// liang_barsky_line_clip_top
// Liang-Barsky clipper of one segment against a csr-held window.
// ----------------------------------------------------------------------------
// Usage:
//   An item (two endpoints) is taken at a clock edge with start high and
//   busy low. busy is always low: the pipeline takes one item every cycle.
//   Each item gives one result item on rsp_data, marked by rsp_strobe for
//   exactly one cycle. Items leave in the order they came.
//   The window registers are written through csr_we/csr_addr/csr_wdata at
//   any edge; change them only while no item is in flight.
//   The divider takes one quotient bit per stage over FRAC_BITS stages;
//   edge setup, classification, min/max, multiply and the final add each
//   sit in a stage of its own.
//   The receiver cannot stall; results are offered once.
//   Reset (synchronous) clears all in-flight items and sets the window to
//   left 0, right 639, top 0, bottom 479.
// ----------------------------------------------------------------------------
module liang_barsky_line_clip_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  lbc_pkg::req_type                        req_data,
   output logic                                    rsp_strobe,
   output lbc_pkg::rsp_type                        rsp_data,
   input  logic                                    csr_we,
   input  logic [lbc_pkg::CSR_AW-1:0]              csr_addr,
   input  logic [lbc_pkg::COORD_WIDTH-1:0]         csr_wdata
);

   localparam int CW  = lbc_pkg::COORD_WIDTH;
   localparam int DW  = lbc_pkg::DIFF_WIDTH;
   localparam int NE  = lbc_pkg::NUM_EDGES;
   localparam int TW  = FRAC_BITS + 1;
   localparam int PW  = TW + DW;
   localparam int LAT = FRAC_BITS + 5;
   localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic                 visible;
      logic [TW-1:0]        t_in;
      logic [TW-1:0]        t_out;
      logic signed [DW-1:0] xs;
      logic signed [DW-1:0] ys;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
   } sel_type;

   typedef struct packed {
      logic                 visible;
      logic                 in_one;
      logic                 out_one;
      logic [PW-1:0]        px_in;
      logic [PW-1:0]        py_in;
      logic [PW-1:0]        px_out;
      logic [PW-1:0]        py_out;
      logic signed [DW-1:0] xs;
      logic signed [DW-1:0] ys;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
   } mul_type;

   // trunc(s + t * d) from the product |d| * t
   function automatic logic [CW-1:0] lerp(input logic signed [DW-1:0] s,
                                          input logic signed [DW-1:0] d,
                                          input logic [PW-1:0] prod,
                                          input logic is_one);
      logic signed [DW:0] s_ext;
      logic signed [DW:0] ip;
      logic signed [DW:0] base;
      logic               frac;
      s_ext = {s[DW-1], s};
      ip    = {1'b0, prod[FRAC_BITS +: DW]};
      frac  = |prod[FRAC_BITS-1:0];
      if (is_one) begin
         base = s_ext + {d[DW-1], d};
      end else if (d[DW-1]) begin
         base = s_ext - ip;
         if (frac && base > 0) base = base - 1'b1;
      end else begin
         base = s_ext + ip;
         if (frac && base < 0) base = base + 1'b1;
      end
      return base[CW-1:0];
   endfunction

   // window registers
   logic signed [CW-1:0] left_ff, right_ff, top_ff, bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= CW'(0);
         right_ff  <= CW'(639);
         top_ff    <= CW'(0);
         bottom_ff <= CW'(479);
      end else if (csr_we) begin
         unique case (csr_addr)
            lbc_pkg::CSR_CLIP_LEFT:   left_ff   <= csr_wdata;
            lbc_pkg::CSR_CLIP_RIGHT:  right_ff  <= csr_wdata;
            lbc_pkg::CSR_CLIP_TOP:    top_ff    <= csr_wdata;
            lbc_pkg::CSR_CLIP_BOTTOM: bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: edge p and q
   logic                          s1_valid_ff;
   logic [NE-1:0][DW-1:0]         p_ff, q_ff;
   logic signed [DW-1:0]          xs1_ff, ys1_ff, dx1_ff, dy1_ff;
   logic signed [DW-1:0]          xs_w, ys_w, xe_w, ye_w;
   logic signed [DW-1:0]          lft_w, rgt_w, top_w, bot_w;

   always_comb begin
      xs_w  = {req_data.x_start[CW-1], req_data.x_start};
      ys_w  = {req_data.y_start[CW-1], req_data.y_start};
      xe_w  = {req_data.x_end[CW-1], req_data.x_end};
      ye_w  = {req_data.y_end[CW-1], req_data.y_end};
      lft_w = {left_ff[CW-1], left_ff};
      rgt_w = {right_ff[CW-1], right_ff};
      top_w = {top_ff[CW-1], top_ff};
      bot_w = {bottom_ff[CW-1], bottom_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      p_ff[0] <= xs_w - xe_w;
      q_ff[0] <= xs_w - lft_w;
      p_ff[1] <= xe_w - xs_w;
      q_ff[1] <= rgt_w - xs_w;
      p_ff[2] <= ys_w - ye_w;
      q_ff[2] <= ys_w - top_w;
      p_ff[3] <= ye_w - ys_w;
      q_ff[3] <= bot_w - ys_w;
      xs1_ff  <= xs_w;
      ys1_ff  <= ys_w;
      dx1_ff  <= xe_w - xs_w;
      dy1_ff  <= ye_w - ys_w;
   end

   // stage 2: classify each edge, magnitudes for the divider
   logic                  s2_valid_ff;
   logic [NE-1:0][DW-1:0] num_ff, den_ff;
   lbc_pkg::side_type     side2_ff;
   logic [NE-1:0][DW-1:0] num_in, den_in;
   lbc_pkg::side_type     side2_in;

   always_comb begin
      side2_in    = '0;
      side2_in.xs = xs1_ff;
      side2_in.ys = ys1_ff;
      side2_in.dx = dx1_ff;
      side2_in.dy = dy1_ff;
      for (int e = 0; e < NE; e++) begin
         num_in[e] = q_ff[e][DW-1] ? DW'(-q_ff[e]) : q_ff[e];
         den_in[e] = p_ff[e][DW-1] ? DW'(-p_ff[e]) : p_ff[e];
         if (p_ff[e] == '0) begin
            side2_in.rej[e] = q_ff[e][DW-1];
         end else if (p_ff[e][DW-1]) begin
            if (q_ff[e][DW-1]) begin
               if (num_in[e] > den_in[e]) begin
                  side2_in.rej[e] = 1'b1;
               end else begin
                  side2_in.used[e]  = 1'b1;
                  side2_in.entry[e] = 1'b1;
                  side2_in.one[e]   = (num_in[e] == den_in[e]);
               end
            end
         end else begin
            if (q_ff[e][DW-1]) begin
               side2_in.rej[e] = 1'b1;
            end else if (num_in[e] < den_in[e]) begin
               side2_in.used[e] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      num_ff   <= num_in;
      den_ff   <= den_in;
      side2_ff <= side2_in;
   end

   // divider stages
   logic                                div_valid;
   logic [NE-1:0][FRAC_BITS-1:0]        div_quo;
   lbc_pkg::side_type                   div_side;

   lbc_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (side2_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // entry is the max of entry candidates, exit the min of exit candidates
   logic    sel_valid_ff;
   sel_type sel_ff, sel_in;
   logic [TW-1:0] cand;

   always_comb begin
      sel_in       = '0;
      sel_in.t_in  = '0;
      sel_in.t_out = T_ONE;
      sel_in.xs    = div_side.xs;
      sel_in.ys    = div_side.ys;
      sel_in.dx    = div_side.dx;
      sel_in.dy    = div_side.dy;
      cand         = '0;
      for (int e = 0; e < NE; e++) begin
         cand = div_side.one[e] ? T_ONE : {1'b0, div_quo[e]};
         if (div_side.used[e] && div_side.entry[e] && cand > sel_in.t_in) begin
            sel_in.t_in = cand;
         end
         if (div_side.used[e] && !div_side.entry[e] && cand < sel_in.t_out) begin
            sel_in.t_out = cand;
         end
      end
      sel_in.visible = !(|div_side.rej) && (sel_in.t_in <= sel_in.t_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= div_valid;
      end
      sel_ff <= sel_in;
   end

   // products of t and the delta magnitudes
   logic    mul_valid_ff;
   mul_type mul_ff, mul_in;
   logic [DW-1:0] mag_dx, mag_dy;

   always_comb begin
      mag_dx         = sel_ff.dx[DW-1] ? DW'(-sel_ff.dx) : sel_ff.dx;
      mag_dy         = sel_ff.dy[DW-1] ? DW'(-sel_ff.dy) : sel_ff.dy;
      mul_in.visible = sel_ff.visible;
      mul_in.in_one  = (sel_ff.t_in == T_ONE);
      mul_in.out_one = (sel_ff.t_out == T_ONE);
      mul_in.px_in   = PW'(sel_ff.t_in) * PW'(mag_dx);
      mul_in.py_in   = PW'(sel_ff.t_in) * PW'(mag_dy);
      mul_in.px_out  = PW'(sel_ff.t_out) * PW'(mag_dx);
      mul_in.py_out  = PW'(sel_ff.t_out) * PW'(mag_dy);
      mul_in.xs      = sel_ff.xs;
      mul_in.ys      = sel_ff.ys;
      mul_in.dx      = sel_ff.dx;
      mul_in.dy      = sel_ff.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= sel_valid_ff;
      end
      mul_ff <= mul_in;
   end

   // final add with truncation toward zero, result register
   logic             rsp_strobe_ff;
   lbc_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in = '0;
      if (mul_ff.visible) begin
         rsp_in.visible      = 1'b1;
         rsp_in.x_clip_start = lerp(mul_ff.xs, mul_ff.dx, mul_ff.px_in, mul_ff.in_one);
         rsp_in.y_clip_start = lerp(mul_ff.ys, mul_ff.dy, mul_ff.py_in, mul_ff.in_one);
         rsp_in.x_clip_end   = lerp(mul_ff.xs, mul_ff.dx, mul_ff.px_out, mul_ff.out_one);
         rsp_in.y_clip_end   = lerp(mul_ff.ys, mul_ff.dy, mul_ff.py_out, mul_ff.out_one);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= mul_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // every result traces back to an item taken at the pipeline input
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result without an item");

   // a rejected segment carries zero coordinates
   a_invisible_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.visible) |->
         (rsp_data.x_clip_start == '0 && rsp_data.y_clip_start == '0 &&
          rsp_data.x_clip_end == '0 && rsp_data.y_clip_end == '0))
      else $error("invisible result with nonzero coordinates");

   // a visible segment has entry at or before exit
   a_t_order: assert property (@(posedge clock) disable iff (reset)
      (sel_valid_ff && sel_ff.visible) |-> (sel_ff.t_in <= sel_ff.t_out))
      else $error("entry beyond exit on a visible segment");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line clipper: a queue of segment items feeds a
// clocked driver, a clocked monitor checks every result item against a
// fixed-point clip predictor run at acceptance time.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW        = lbc_pkg::COORD_WIDTH;
   localparam int FRAC_BITS = 16;
   localparam longint T_ONE = 64'd1 << FRAC_BITS;
   localparam int LATENCY   = FRAC_BITS + 5;
   localparam int WDOG_MAX  = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lbc_pkg::req_type req_data = '0;
   logic rsp_strobe;
   lbc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [lbc_pkg::CSR_AW-1:0] csr_addr = lbc_pkg::CSR_CLIP_LEFT;
   logic [CW-1:0] csr_wdata = '0;

   liang_barsky_line_clip_top #(.FRAC_BITS(FRAC_BITS)) i_dut (.*);

   // window as the predictor sees it
   logic signed [CW-1:0] win_left = 0, win_right = 639;
   logic signed [CW-1:0] win_top = 0, win_bottom = 479;

   lbc_pkg::req_type segs_pending[$];
   lbc_pkg::rsp_type clips_expected[$];
   int send_idle_pct = 0;
   int mismatches = 0;
   int stall_cycles = 0;

   // floor(n * 2^FRAC_BITS / d) for 0 < n <= d
   function automatic longint quot_t(longint n, longint d);
      if (n >= d) return T_ONE;
      return (n << FRAC_BITS) / d;
   endfunction

   // one edge of the clip test
   function automatic void clip_edge(longint p, longint q, ref longint t_in,
                                     ref longint t_out, ref bit rej);
      longint c;
      if (p == 0) begin
         if (q < 0) rej = 1;
      end else if (p < 0) begin
         if (q < 0) begin
            if (-q > -p) rej = 1;
            else begin
               c = quot_t(-q, -p);
               if (c > t_in) t_in = c;
            end
         end
      end else begin
         if (q < 0) rej = 1;
         else if (q < p) begin
            c = (q == 0) ? 0 : quot_t(q, p);
            if (c < t_out) t_out = c;
         end
      end
   endfunction

   // start + t * delta, truncated toward zero
   function automatic logic [CW-1:0] interp(longint s, longint d, longint t);
      longint mag, ip, base;
      bit frac;
      if (t >= T_ONE) return CW'(s + d);
      mag  = (d < 0) ? -d : d;
      ip   = (t * mag) >> FRAC_BITS;
      frac = ((t * mag) & (T_ONE - 1)) != 0;
      if (d >= 0) begin
         base = s + ip;
         if (frac && base < 0) base += 1;
      end else begin
         base = s - ip;
         if (frac && base > 0) base -= 1;
      end
      return base[CW-1:0];
   endfunction

   function automatic lbc_pkg::rsp_type clip_segment(lbc_pkg::req_type r);
      longint xs, ys, dx, dy, t_in, t_out;
      bit rej;
      lbc_pkg::rsp_type o;
      xs = r.x_start; ys = r.y_start;
      dx = longint'(r.x_end) - xs; dy = longint'(r.y_end) - ys;
      t_in = 0; t_out = T_ONE; rej = 0;
      clip_edge(-dx, xs - win_left, t_in, t_out, rej);
      clip_edge(dx, longint'(win_right) - xs, t_in, t_out, rej);
      clip_edge(-dy, ys - win_top, t_in, t_out, rej);
      clip_edge(dy, longint'(win_bottom) - ys, t_in, t_out, rej);
      o = '0;
      if (!rej && t_in <= t_out) begin
         o.visible      = 1'b1;
         o.x_clip_start = interp(xs, dx, t_in);
         o.y_clip_start = interp(ys, dy, t_in);
         o.x_clip_end   = interp(xs, dx, t_out);
         o.y_clip_end   = interp(ys, dy, t_out);
      end
      return o;
   endfunction

   initial begin
      forever #6 clock = ~clock;
   end

   // driver: start stays high across back-to-back items
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            clips_expected.push_back(clip_segment(req_data));
         end
         if ((!start || !busy) && !(start && busy)) begin
            if (segs_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= segs_pending.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      lbc_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (clips_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %p", rsp_data);
         end else begin
            want = clips_expected.pop_front();
            if (rsp_data.visible !== want.visible ||
                rsp_data.x_clip_start !== want.x_clip_start ||
                rsp_data.y_clip_start !== want.y_clip_start ||
                rsp_data.x_clip_end !== want.x_clip_end ||
                rsp_data.y_clip_end !== want.y_clip_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted and no result
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WDOG_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic lbc_pkg::req_type seg(int xs, int ys, int xe, int ye);
      lbc_pkg::req_type r;
      r.x_start = CW'(xs); r.y_start = CW'(ys); r.x_end = CW'(xe); r.y_end = CW'(ye);
      return r;
   endfunction

   // random segment: mostly near the window, some full range
   function automatic lbc_pkg::req_type rand_seg();
      lbc_pkg::req_type r;
      if ($urandom_range(3) == 0) begin
         r = {$urandom, $urandom};
      end else begin
         r.x_start = CW'(int'(win_left) - 200 + int'($urandom_range(1000)));
         r.y_start = CW'(int'(win_top) - 200 + int'($urandom_range(900)));
         r.x_end   = CW'(int'(win_left) - 200 + int'($urandom_range(1000)));
         r.y_end   = CW'(int'(win_top) - 200 + int'($urandom_range(900)));
         if ($urandom_range(9) == 0) r.x_end = r.x_start;
         if ($urandom_range(9) == 0) r.y_end = r.y_start;
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (segs_pending.size() > 0 || start || clips_expected.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_window(int l, int r, int t, int b);
      logic [CW-1:0] vals[4];
      vals = '{l[15:0], r[15:0], t[15:0], b[15:0]};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= lbc_pkg::CSR_AW'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      win_left = CW'(l); win_right = CW'(r); win_top = CW'(t); win_bottom = CW'(b);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         while (segs_pending.size() > 8) @(posedge clock);
         segs_pending.push_back(rand_seg());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window, extremes, degenerate and edge-touching cases
      segs_pending.push_back(seg(-100, 240, 800, 240));
      segs_pending.push_back(seg(320, -50, 320, 600));
      segs_pending.push_back(seg(10, 10, 100, 100));
      segs_pending.push_back(seg(-32768, -32768, 32767, 32767));
      segs_pending.push_back(seg(32767, -32768, -32768, 32767));
      segs_pending.push_back(seg(5, 5, 5, 5));
      segs_pending.push_back(seg(0, 0, 0, 0));
      segs_pending.push_back(seg(639, 479, 639, 479));
      segs_pending.push_back(seg(-1, 5, -1, 5));
      segs_pending.push_back(seg(-10, -10, -5, -20));
      segs_pending.push_back(seg(700, 100, 900, 100));
      segs_pending.push_back(seg(0, 0, 639, 0));
      segs_pending.push_back(seg(-5, 100, 0, 100));
      segs_pending.push_back(seg(800, 500, -100, -30));
      segs_pending.push_back(seg(-100, 600, 700, -100));
      segs_pending.push_back(seg(-1, -1, -1, -1));
      segs_pending.push_back(seg(100, 480, 200, 480));
      wait_drained();

      // full-range window, then inverted window
      write_window(-32768, 32767, -32768, 32767);
      segs_pending.push_back(seg(-32768, 32767, 32767, -32768));
      segs_pending.push_back(seg(3, -7, -11, 13));
      wait_drained();
      write_window(100, 50, 0, 479);
      segs_pending.push_back(seg(0, 10, 200, 10));
      segs_pending.push_back(seg(75, 10, 75, 10));
      wait_drained();

      // random phases: sender idles lightly, then heavily, then not at all
      write_window(-300, 400, -250, 300);
      send_idle_pct = 13;
      random_phase(350);
      wait_drained();
      write_window(0, 639, 0, 479);
      send_idle_pct = 48;
      random_phase(350);
      wait_drained();
      send_idle_pct = 0;
      write_window(32000, 32767, -32768, -32000);
      random_phase(60);
      wait_drained();
      write_window(-20, -10, 7, 9);
      random_phase(340);
      wait_drained();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

/* files.f */
hdl/lbc_pkg.sv
hdl/lbc_div.sv
hdl/liang_barsky_line_clip_top.sv
verif/tb.sv
